>>> design/gmt_pkg.sv
`timescale 1ns / 1ps

package gmt_pkg;

  // Default sizing of the block.
  localparam int GMT_MAX_DIM    = 16;
  localparam int GMT_ELEM_WIDTH = 32;

  // Fixed widths of the request, response and configuration fields.
  localparam int DIM_W   = 5;
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int REG_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_RD   = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [REG_W-1:0] {
    REG_DIM_L   = 3'd0,
    REG_DIM_M   = 3'd1,
    REG_DIM_N   = 3'd2,
    REG_TRANS_A = 3'd3,
    REG_TRANS_B = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim_l;
    logic [DIM_W-1:0] dim_m;
    logic [DIM_W-1:0] dim_n;
    logic             trans_a;
    logic             trans_b;
  } cfg_t;

endpackage

>>> design/gmt_req_if.sv
`timescale 1ns / 1ps

interface gmt_req_if import gmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   col;
  logic [VALUE_W-1:0] load_value;

  modport source (output valid, operation, row, col, load_value, input ready);
  modport sink   (input valid, operation, row, col, load_value, output ready);
endinterface

>>> design/gmt_rsp_if.sv
`timescale 1ns / 1ps

interface gmt_rsp_if import gmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] product_value;
  logic               index_error;

  modport source (output valid, product_value, index_error, input ready);
  modport sink   (input valid, product_value, index_error, output ready);
endinterface

>>> design/gmt_cfg_if.sv
`timescale 1ns / 1ps

interface gmt_cfg_if import gmt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] index;
  logic [DIM_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/gmt_cfg_regs.sv
`timescale 1ns / 1ps

module gmt_cfg_regs import gmt_pkg::*; #(
  parameter int MAX_DIM = GMT_MAX_DIM
) (
  input  logic      clk,
  input  logic      rst,
  gmt_cfg_if.sink   cfg_port,
  output cfg_t      cfg
);

  // Largest value a dimension register can hold after saturation.
  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIM > 31) ? DIM_W'(31) : DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] dim_sat;

  assign cfg_port.ready = 1'b1;
  assign dim_sat = (cfg_port.data > DIM_CAP) ? DIM_CAP : cfg_port.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_l   <= DIM_W'(1);
      cfg.dim_m   <= DIM_W'(1);
      cfg.dim_n   <= DIM_W'(1);
      cfg.trans_a <= 1'b0;
      cfg.trans_b <= 1'b0;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        REG_DIM_L:   cfg.dim_l   <= dim_sat;
        REG_DIM_M:   cfg.dim_m   <= dim_sat;
        REG_DIM_N:   cfg.dim_n   <= dim_sat;
        REG_TRANS_A: cfg.trans_a <= cfg_port.data[0];
        REG_TRANS_B: cfg.trans_b <= cfg_port.data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/gmt_mem.sv
`timescale 1ns / 1ps

module gmt_mem #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/gmt_mac.sv
`timescale 1ns / 1ps

module gmt_mac #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  issue,
  input  logic [ELEM_WIDTH-1:0] a_data,
  input  logic [ELEM_WIDTH-1:0] b_data,
  output logic [ELEM_WIDTH-1:0] acc,
  output logic                  busy
);

  // Valid flags: operands at the memory outputs, products registered,
  // product assembled and ready to be added.
  logic                  v_rd;
  logic                  v_mul;
  logic                  v_prod;
  logic [ELEM_WIDTH-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd   <= 1'b0;
      v_mul  <= 1'b0;
      v_prod <= 1'b0;
    end else begin
      v_rd   <= issue;
      v_mul  <= v_rd;
      v_prod <= v_mul;
    end
  end

  generate
    if (ELEM_WIDTH > 32) begin : g_wide
      // Wide elements are split at bit 32; only the low ELEM_WIDTH bits of
      // the product are kept, so the high by high term drops out.
      localparam int HW = ELEM_WIDTH - 32;
      logic [63:0]   p_ll;
      logic [HW-1:0] p_lh;
      logic [HW-1:0] p_hl;

      always_ff @(posedge clk) begin
        p_ll <= 64'(a_data[31:0]) * 64'(b_data[31:0]);
        p_lh <= HW'(a_data[31:0] * 32'(b_data[ELEM_WIDTH-1:32]));
        p_hl <= HW'(32'(a_data[ELEM_WIDTH-1:32]) * b_data[31:0]);
        prod <= ELEM_WIDTH'(p_ll) + {HW'(p_lh + p_hl), 32'b0};
      end
    end else begin : g_narrow
      logic [ELEM_WIDTH-1:0] p_full;

      always_ff @(posedge clk) begin
        p_full <= a_data * b_data;
        prod   <= p_full;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (v_prod) begin
      acc <= acc + prod;
    end
  end

  assign busy = v_rd | v_mul | v_prod;

endmodule

>>> design/integer_gemm_with_transpose_core.sv
`timescale 1ns / 1ps

// Integer matrix multiply, C = op(A) x op(B), with either operand optionally
// transposed and all arithmetic wrapping at ELEM_WIDTH bits. Elements of A and
// B are loaded one request at a time at their position in the stored shape,
// and a read request returns one entry of the product. A write leaves no
// response unless its position lies outside the shape, in which case the
// block passes through its emit state and returns a response with index_error
// set. A read walks the inner dimension through one multiply-accumulate unit
// fed by the A and B memories, one pair per cycle: the block accepts the read,
// issues dim_m memory reads, waits in its drain state for memory latency and
// the multiply pipeline to empty, and loads the response register once it is
// free. With dim_m at zero nothing is issued and the read passes to the drain
// state with the pipeline already empty. An out-of-shape read goes straight to
// the emit state. The response sits in its own register, so further requests
// are taken while an earlier response still waits to be collected. The user
// writes configuration through its own channel, which is always ready, only
// while the block is idle; the block itself does not enforce this.
module integer_gemm_with_transpose_core import gmt_pkg::*; #(
  parameter int MAX_DIM    = GMT_MAX_DIM,
  parameter int ELEM_WIDTH = GMT_ELEM_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  gmt_cfg_if.sink    cfg,
  gmt_req_if.sink    req,
  gmt_rsp_if.source  rsp
);

  // Each operand memory is addressed by {row, col}, each on IW bits.
  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;

  cfg_t                  cfg_q;
  state_t                state;
  state_t                state_next;

  logic [DIM_W-1:0]      k;
  logic [POS_W-1:0]      row_q;
  logic [POS_W-1:0]      col_q;
  logic                  err_q;

  logic                  req_accept;
  logic                  slot_free;
  logic                  load_rsp;
  logic                  issue;
  logic                  req_err;
  logic                  last_k;
  logic [DIM_W-1:0]      rows;
  logic [DIM_W-1:0]      cols;

  logic                  a_we;
  logic                  b_we;
  logic [AW-1:0]         waddr;
  logic [ELEM_WIDTH-1:0] wdata;
  logic [AW-1:0]         a_raddr;
  logic [AW-1:0]         b_raddr;
  logic [ELEM_WIDTH-1:0] a_rdata;
  logic [ELEM_WIDTH-1:0] b_rdata;
  logic [ELEM_WIDTH-1:0] acc;
  logic                  mac_busy;

  gmt_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_port (cfg),
    .cfg      (cfg_q)
  );

  // The shape a request is checked against depends on what it addresses:
  // the stored shape of A or B, or the shape of the product for a read.
  always_comb begin
    case (op_t'(req.operation))
      OP_WR_A: begin
        rows = cfg_q.trans_a ? cfg_q.dim_m : cfg_q.dim_l;
        cols = cfg_q.trans_a ? cfg_q.dim_l : cfg_q.dim_m;
      end
      OP_WR_B: begin
        rows = cfg_q.trans_b ? cfg_q.dim_n : cfg_q.dim_m;
        cols = cfg_q.trans_b ? cfg_q.dim_m : cfg_q.dim_n;
      end
      default: begin
        rows = cfg_q.dim_l;
        cols = cfg_q.dim_n;
      end
    endcase
  end

  assign req_err    = ({1'b0, req.row} >= rows) || ({1'b0, req.col} >= cols);
  assign req_accept = req.valid && req.ready;
  assign slot_free  = !rsp.valid || rsp.ready;
  assign last_k     = (k == cfg_q.dim_m - DIM_W'(1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          unique case (op_t'(req.operation))
            OP_WR_A, OP_WR_B: state_next = req_err ? ST_EMIT : ST_IDLE;
            OP_RD: begin
              if (req_err) begin
                state_next = ST_EMIT;
              end else if (cfg_q.dim_m == '0) begin
                state_next = ST_DRAIN;
              end else begin
                state_next = ST_RUN;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    issue     = 1'b0;
    load_rsp  = 1'b0;
    unique case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_RUN:   issue     = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  load_rsp  = slot_free;
      default: ;
    endcase
  end

  // An in-shape write goes straight into its memory at the accepting edge,
  // so any later read sees it without forwarding.
  assign a_we  = req_accept && !req_err && (op_t'(req.operation) == OP_WR_A);
  assign b_we  = req_accept && !req_err && (op_t'(req.operation) == OP_WR_B);
  assign waddr = {IW'(req.row), IW'(req.col)};
  assign wdata = ELEM_WIDTH'(req.load_value);

  // Step k walks row row_q of op(A) and column col_q of op(B).
  assign a_raddr = cfg_q.trans_a ? {IW'(k), IW'(row_q)} : {IW'(row_q), IW'(k)};
  assign b_raddr = cfg_q.trans_b ? {IW'(col_q), IW'(k)} : {IW'(k), IW'(col_q)};

  gmt_mem #(
    .AW (AW),
    .DW (ELEM_WIDTH)
  ) u_a_mem (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  gmt_mem #(
    .AW (AW),
    .DW (ELEM_WIDTH)
  ) u_b_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  gmt_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (req_accept),
    .issue  (issue),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .acc    (acc),
    .busy   (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      k     <= '0;
      row_q <= req.row;
      col_q <= req.col;
      err_q <= req_err;
    end else if (issue) begin
      k <= k + DIM_W'(1);
    end
  end

  // Response register: freed when taken, refilled only when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.product_value <= err_q ? '0 : VALUE_W'(acc);
      rsp.index_error   <= err_q;
    end
  end

endmodule

>>> design/gmt_checker.sv
`timescale 1ns / 1ps

module gmt_checker import gmt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic [OP_W-1:0]    req_operation,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [VALUE_W-1:0] rsp_product_value,
  input logic               rsp_index_error
);

  // A response that is not taken stays in place unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_product_value) && $stable(rsp_index_error))
    else $error("response changed while stalled");

  // An index error always carries a zero product.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_index_error |-> rsp_product_value == '0)
    else $error("index error with non-zero product");

  // A read keeps the block busy, so no request is taken in the next cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_operation == OP_RD) |=> !req_ready)
    else $error("request taken straight after a read");

  // Reset leaves no response pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response pending after reset");

endmodule

bind integer_gemm_with_transpose_core gmt_checker u_gmt_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_operation     (req.operation),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_product_value (rsp.product_value),
  .rsp_index_error   (rsp.index_error)
);

>>> tb/tb_integer_gemm_with_transpose_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the integer GEMM core. Requests are driven on the
// request channel in bursts, responses are collected under a stall pattern of
// the bench's own, and every accepted request is run through a shadow copy of
// the matrix stores and configuration so that the awaited response, if any, can
// be queued and compared field by field when the block returns it.
module tb_integer_gemm_with_transpose_core import gmt_pkg::*;;

  localparam int TOTAL_ITEMS    = 1350;
  // Pause before any register is touched, long enough for a read to pass through
  // the block.
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STORE_DEPTH    = GMT_MAX_DIM * GMT_MAX_DIM;

  // Register indexes that the block does not decode and must ignore.
  localparam logic [REG_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] product_value;
    logic               index_error;
  } product_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } slot_t;

  // A directed row is either a register write, a request whose response comes
  // from the shadow model, or a request whose response is written out in full.
  typedef enum logic [1:0] {
    STEP_PREDICT,
    STEP_TYPED,
    STEP_CFG
  } step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [REG_W-1:0]   reg_sel;
    logic [DIM_W-1:0]   reg_data;
    op_t                op;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VALUE_W-1:0] load;
    logic [VALUE_W-1:0] product_value;
    logic               index_error;
  } step_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_MOSTLY,
    RX_PERIODIC
  } rx_mode_t;

  localparam int DIRECTED_LEN = 33;

  // The block starts out 1 x 1 x 1 with no transposes. The first group covers
  // the single-entry product, including the all-ones product that wraps to one
  // and a product that wraps to zero, out-of-shape writes and reads on every
  // edge, and the unused operation code. The second group saturates dim_l and
  // dim_n, zeroes dim_m so that an in-shape read yields zero without touching
  // either store, turns both transposes on and writes the undecoded register
  // indexes. The last groups zero dim_l and then dim_n.
  localparam step_t DIRECTED [DIRECTED_LEN] = '{
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_WR_A, 4'd0,  4'd0,  32'hFFFF_FFFF, 32'd0, 1'b0},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_WR_B, 4'd0,  4'd0,  32'hFFFF_FFFF, 32'd0, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd0,  4'd0,  32'h0,         32'd1, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_WR_A, 4'd1,  4'd0,  32'h1234_5678, 32'd0, 1'b1},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_WR_B, 4'd0,  4'd15, 32'h8765_4321, 32'd0, 1'b1},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd15, 4'd15, 32'hFFFF_FFFF, 32'd0, 1'b1},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd0,  4'd1,  32'h0,         32'd0, 1'b1},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_NONE, 4'd15, 4'd15, 32'hAAAA_AAAA, 32'd0, 1'b0},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_WR_A, 4'd0,  4'd0,  32'h0000_0002, 32'd0, 1'b0},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_WR_B, 4'd0,  4'd0,  32'h8000_0000, 32'd0, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_WR_A, 4'd0,  4'd0,  32'h1234_5678, 32'd0, 1'b0},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_WR_B, 4'd0,  4'd0,  32'h9ABC_DEF1, 32'd0, 1'b0},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_RD,   4'd0,  4'd0,  32'h5555_5555, 32'd0, 1'b0},
    '{STEP_CFG,     REG_DIM_L,    5'd31, OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_CFG,     REG_DIM_M,    5'd0,  OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_CFG,     REG_DIM_N,    5'd17, OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_CFG,     REG_TRANS_A,  5'd1,  OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_CFG,     REG_TRANS_B,  5'd31, OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_CFG,     REG_SPARE_LO, 5'd3,  OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_CFG,     REG_SPARE_HI, 5'd31, OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd15, 4'd15, 32'h0,         32'd0, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd0,  4'd0,  32'hFFFF_FFFF, 32'd0, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_WR_A, 4'd0,  4'd0,  32'h5555_5555, 32'd0, 1'b1},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_WR_B, 4'd15, 4'd0,  32'hFFFF_FFFF, 32'd0, 1'b1},
    '{STEP_CFG,     REG_DIM_L,    5'd0,  OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_CFG,     REG_DIM_M,    5'd1,  OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd0,  4'd0,  32'h0,         32'd0, 1'b1},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_WR_A, 4'd0,  4'd0,  32'h0000_0001, 32'd0, 1'b1},
    '{STEP_PREDICT, REG_DIM_L,    5'd0,  OP_WR_B, 4'd15, 4'd0,  32'h0F0F_0F0F, 32'd0, 1'b0},
    '{STEP_CFG,     REG_DIM_N,    5'd0,  OP_NONE, 4'd0,  4'd0,  32'h0,         32'd0, 1'b0},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_RD,   4'd0,  4'd0,  32'h0,         32'd0, 1'b1},
    '{STEP_TYPED,   REG_DIM_L,    5'd0,  OP_WR_B, 4'd0,  4'd0,  32'hF0F0_F0F0, 32'd0, 1'b1}
  };

  logic clk = 1'b0;
  logic rst;

  gmt_cfg_if cfg ();
  gmt_req_if req ();
  gmt_rsp_if rsp ();

  integer_gemm_with_transpose_core i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  // Shadow copy of the block: both operand stores, a record of which entries
  // have been written, and the configuration as the block should hold it.
  logic [VALUE_W-1:0] mat_a [STORE_DEPTH];
  logic [VALUE_W-1:0] mat_b [STORE_DEPTH];
  bit                 a_written [STORE_DEPTH];
  bit                 b_written [STORE_DEPTH];
  logic [DIM_W-1:0]   cur_l = 5'd1;
  logic [DIM_W-1:0]   cur_m = 5'd1;
  logic [DIM_W-1:0]   cur_n = 5'd1;
  logic               cur_ta = 1'b0;
  logic               cur_tb = 1'b0;

  product_t    owed_products [$];
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  // Position in the A store of element k of row r of op(A), and likewise in
  // the B store of element k of column c of op(B).
  function automatic logic [2*POS_W-1:0] a_index(input int k, input logic [POS_W-1:0] r);
    return cur_ta ? {POS_W'(k), r} : {r, POS_W'(k)};
  endfunction

  function automatic logic [2*POS_W-1:0] b_index(input int k, input logic [POS_W-1:0] c);
    return cur_tb ? {c, POS_W'(k)} : {POS_W'(k), c};
  endfunction

  function automatic void stored_shape(input op_t op, output logic [DIM_W-1:0] rows,
                                       output logic [DIM_W-1:0] cols);
    if (op == OP_WR_A) begin
      rows = cur_ta ? cur_m : cur_l;
      cols = cur_ta ? cur_l : cur_m;
    end else begin
      rows = cur_tb ? cur_n : cur_m;
      cols = cur_tb ? cur_m : cur_n;
    end
  endfunction

  // True when every entry that the product at (r, c) draws on has been loaded.
  function automatic bit operands_written(input logic [POS_W-1:0] r,
                                          input logic [POS_W-1:0] c);
    int k;
    for (k = 0; k < cur_m; k++) begin
      if (!a_written[a_index(k, r)] || !b_written[b_index(k, c)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one request to the shadow state and reports whether it leaves a
  // response, which is then returned in rsp_out.
  function automatic bit predict_response(input op_t op, input logic [POS_W-1:0] r,
                                          input logic [POS_W-1:0] c,
                                          input logic [VALUE_W-1:0] v,
                                          output product_t rsp_out);
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [VALUE_W-1:0] acc;
    int                 k;
    rsp_out = '0;
    case (op)
      OP_WR_A, OP_WR_B: begin
        stored_shape(op, rows, cols);
        if (r >= rows || c >= cols) begin
          rsp_out.index_error = 1'b1;
          return 1'b1;
        end
        if (op == OP_WR_A) begin
          mat_a[{r, c}]     = v;
          a_written[{r, c}] = 1'b1;
        end else begin
          mat_b[{r, c}]     = v;
          b_written[{r, c}] = 1'b1;
        end
        return 1'b0;
      end
      OP_RD: begin
        if (r >= cur_l || c >= cur_n) begin
          rsp_out.index_error = 1'b1;
          return 1'b1;
        end
        // The accumulator is as wide as an element, so the sum wraps as the
        // hardware's does.
        acc = '0;
        for (k = 0; k < cur_m; k++) acc = acc + mat_a[a_index(k, r)] * mat_b[b_index(k, c)];
        rsp_out.product_value = acc;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] saturate_dim(input logic [DIM_W-1:0] data);
    return (data > GMT_MAX_DIM) ? DIM_W'(GMT_MAX_DIM) : data;
  endfunction

  // Drives one register write and leaves cfg.valid high; whoever ends a run of
  // writes lowers it, so that it is never lowered and raised in one step.
  task automatic write_register(input logic [REG_W-1:0] sel, input logic [DIM_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= sel;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (sel)
      REG_DIM_L:   cur_l  = saturate_dim(data);
      REG_DIM_M:   cur_m  = saturate_dim(data);
      REG_DIM_N:   cur_n  = saturate_dim(data);
      REG_TRANS_A: cur_ta = data[0];
      REG_TRANS_B: cur_tb = data[0];
      default: ;
    endcase
  endtask

  // Drives one request in the current burst and waits for it to be taken. A new
  // burst begins with a gap of random length, or with none at all.
  task automatic send_request(input op_t op, input logic [POS_W-1:0] r,
                              input logic [POS_W-1:0] c, input logic [VALUE_W-1:0] v,
                              input bit typed, input product_t typed_rsp);
    int unsigned gap;
    bit          has_rsp;
    product_t    predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.row        <= r;
    req.col        <= c;
    req.load_value <= v;
    do @(posedge clk); while (!req.ready);
    has_rsp = predict_response(op, r, c, v, predicted);
    if (typed) owed_products.push_back(typed_rsp);
    else if (has_rsp) owed_products.push_back(predicted);
    if (op != OP_NONE) items_sent++;
  endtask

  // Stops sending and waits for every outstanding response. It waits on the
  // clock first, so a following request never raises valid in the step it fell.
  task automatic hold_until_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (owed_products.size() != 0);
  endtask

  // A write leaves no response, so the block is given time to finish one
  // before its configuration is touched.
  task automatic settle_block();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a full random word, with all-zero, all-one and small values mixed in
  // so that products wrap often and zero terms appear.
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    if (pick < 30) return VALUE_W'($urandom_range(0, 15));
    return VALUE_W'($urandom);
  endfunction

  // Small shapes most of the time, the full size and saturating codes now and
  // then, and an empty axis rarely.
  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return '0;
    if (pick < 14) return DIM_W'($urandom_range(16, 31));
    if (pick < 24) return DIM_W'(1);
    return DIM_W'($urandom_range(2, 6));
  endfunction

  // One request after the operands are loaded: mostly reads in shape, with
  // overwrites, out-of-shape traffic and the unused code mixed in. A noisy
  // phase draws everything at random instead.
  task automatic random_request(input bit shaped);
    op_t              op;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    r    = POS_W'($urandom_range(0, 15));
    c    = POS_W'($urandom_range(0, 15));
    if (!shaped) begin
      op = op_t'($urandom_range(0, 3));
    end else if (pick < 60) begin
      op = OP_RD;
      if (cur_l != 0) r = POS_W'($urandom_range(0, cur_l - 1));
      if (cur_n != 0) c = POS_W'($urandom_range(0, cur_n - 1));
    end else if (pick < 70) begin
      op = OP_RD;
    end else if (pick < 88) begin
      op = $urandom_range(0, 1) ? OP_WR_B : OP_WR_A;
      stored_shape(op, rows, cols);
      if (pick < 80 && rows != 0 && cols != 0) begin
        r = POS_W'($urandom_range(0, rows - 1));
        c = POS_W'($urandom_range(0, cols - 1));
      end
    end else if (pick < 92) begin
      op = OP_NONE;
    end else begin
      op = OP_RD;
      r  = '1;
      c  = '1;
    end
    // A product entry may only be read once everything it draws on is loaded.
    if (op == OP_RD && r < cur_l && c < cur_n && !operands_written(r, c)) op = OP_WR_A;
    send_request(op, r, c, random_value(), 1'b0, '0);
  endtask

  // One phase: a fresh configuration, a full load of both operands in random
  // order in most phases, and then a run of mixed requests.
  task automatic random_phase();
    slot_t            slots [$];
    slot_t            held;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    bit               shaped;
    int               i;
    int               j;
    int               r;
    int               c;
    settle_block();
    write_register(REG_DIM_L, pick_dim());
    write_register(REG_DIM_M, pick_dim());
    write_register(REG_DIM_N, pick_dim());
    write_register(REG_TRANS_A, DIM_W'($urandom));
    write_register(REG_TRANS_B, DIM_W'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      write_register(REG_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), DIM_W'($urandom));
    end
    cfg.valid <= 1'b0;
    shaped = ($urandom_range(0, 9) != 0);
    if (shaped) begin
      stored_shape(OP_WR_A, rows, cols);
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) slots.push_back('{OP_WR_A, POS_W'(r), POS_W'(c)});
      end
      stored_shape(OP_WR_B, rows, cols);
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) slots.push_back('{OP_WR_B, POS_W'(r), POS_W'(c)});
      end
      for (i = slots.size() - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        held     = slots[i];
        slots[i] = slots[j];
        slots[j] = held;
      end
      foreach (slots[i]) begin
        send_request(slots[i].op, slots[i].row, slots[i].col, random_value(), 1'b0, '0);
      end
    end
    repeat ($urandom_range(8, 40)) begin
      // Now and then the sender goes quiet until the block has answered
      // everything, so that requests also meet a completely idle block.
      if ($urandom_range(0, 39) == 0) hold_until_drained();
      random_request(shaped);
    end
  endtask

  // Response side: each stretch picks a mode, from always ready through coin
  // tosses to a fixed on/off pattern of its own period.
  initial begin : response_sink
    rx_mode_t    mode;
    int unsigned span;
    int unsigned period;
    int unsigned duty;
    int unsigned beat;
    rsp.ready = 1'b0;
    forever begin
      mode   = rx_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(16, 160);
      period = $urandom_range(2, 20);
      duty   = $urandom_range(1, period - 1);
      for (beat = 0; beat < span; beat++) begin
        @(posedge clk);
        case (mode)
          RX_STREAM: rsp.ready <= 1'b1;
          RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: rsp.ready <= ($urandom_range(0, 4) != 0);
          default:   rsp.ready <= ((beat % period) < duty);
        endcase
      end
    end
  end

  // Every response taken is matched against the oldest one still owed.
  always @(posedge clk) begin
    product_t owed;
    if (!rst && rsp.valid && rsp.ready) begin
      if (owed_products.size() == 0) begin
        $error("response with none owed: product_value %h index_error %b",
               rsp.product_value, rsp.index_error);
        fail_count++;
      end else begin
        owed = owed_products.pop_front();
        if (rsp.product_value !== owed.product_value) begin
          $error("product_value: expected %h, got %h", owed.product_value, rsp.product_value);
          fail_count++;
        end
        if (rsp.index_error !== owed.index_error) begin
          $error("index_error: expected %b, got %b", owed.index_error, rsp.index_error);
          fail_count++;
        end
      end
    end
  end

  // The run is abandoned if no channel moves anything for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("integer_gemm_with_transpose_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    step_t step;
    int    i;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.operation  = OP_NONE;
    req.row        = '0;
    req.col        = '0;
    req.load_value = '0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_DIM_L;
    cfg.data       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table. A run of register writes is preceded by a pause for the
    // block to go idle, and cfg.valid is lowered once the run is over.
    for (i = 0; i < DIRECTED_LEN; i++) begin
      step = DIRECTED[i];
      if (step.kind == STEP_CFG) begin
        if (i == 0 || DIRECTED[i-1].kind != STEP_CFG) settle_block();
        write_register(step.reg_sel, step.reg_data);
        if (i == DIRECTED_LEN - 1 || DIRECTED[i+1].kind != STEP_CFG) cfg.valid <= 1'b0;
      end else begin
        send_request(step.op, step.row, step.col, step.load, step.kind == STEP_TYPED,
                     '{step.product_value, step.index_error});
      end
    end

    while (items_sent < TOTAL_ITEMS) random_phase();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_gemm_with_transpose_core verification clean");
    end else begin
      $display("integer_gemm_with_transpose_core verification failed");
    end
    $finish;
  end

endmodule
